// ===== rtl/omni_wheel_speed_mixer_assert.svh =====
// Assertion macros for the omni-wheel speed mixer.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef OMNI_WHEEL_SPEED_MIXER_ASSERT_SVH
`define OMNI_WHEEL_SPEED_MIXER_ASSERT_SVH
`ifndef SYNTH
// a implies b in the same cycle
`define OWSM_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("owsm assertion failed");
// a implies b in the next cycle
`define OWSM_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("owsm assertion failed");
`else
`define OWSM_ASSERT_NOW(label, clk, rst, a, b)
`define OWSM_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/owsm_pkg.sv =====
// Types, constants and helper functions shared by the omni-wheel mixer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package owsm_pkg;

  localparam int XW           = 19;     // CORDIC x/y width, Q16 signed
  localparam int ZW           = 18;     // CORDIC residue width, turn units
  localparam int CORDIC_STEPS = 14;
  localparam int CORDIC_GAIN  = 39797;  // gain-compensated 1.0 in Q16
  localparam int ANGLE_REGS   = 6;
  localparam int SPEED_MAX    = 131071;
  localparam int SPEED_MIN    = -131072;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_WHEEL_COUNT = 3'd0;
  localparam logic [2:0] REG_ANGLE_0     = 3'd1;
  localparam logic [2:0] REG_ANGLE_5     = 3'd6;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_vec_t;

  typedef struct packed {
    logic signed [8:0]  speed;
    logic signed [16:0] rot;
    logic [2:0]         idx;
    logic               last;
    logic               hflip;
    logic               wflip;
  } side_t;

  typedef struct packed {
    cordic_vec_t hv;    // heading
    cordic_vec_t wv;    // wheel mounting angle
    side_t       side;
  } stage_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int step);
    logic signed [ZW-1:0] r;
    case (step)
      0:  r = ZW'(8192);
      1:  r = ZW'(4836);
      2:  r = ZW'(2555);
      3:  r = ZW'(1297);
      4:  r = ZW'(651);
      5:  r = ZW'(326);
      6:  r = ZW'(163);
      7:  r = ZW'(81);
      8:  r = ZW'(41);
      9:  r = ZW'(20);
      10: r = ZW'(10);
      11: r = ZW'(5);
      12: r = ZW'(3);
      default: r = ZW'(1);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/owsm_if.sv =====
// Valid/ready channels for motion commands and wheel results.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface owsm_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [8:0]  speed_magnitude;
  logic [15:0]        heading;
  logic signed [16:0] rotation;
  modport source (output valid, speed_magnitude, heading, rotation, input ready);
  modport sink (input valid, speed_magnitude, heading, rotation, output ready);
endinterface

interface owsm_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         wheel_index;
  logic signed [17:0] wheel_speed;
  logic               last;
  modport source (output valid, wheel_index, wheel_speed, last, input ready);
  modport sink (input valid, wheel_index, wheel_speed, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/omni_wheel_speed_mixer.sv =====
// Omni-wheel speed mixer top level: registers, wheel issue, CORDIC chain, output.
// Depends on owsm_pkg, owsm_if, owsm_cordic_cell, owsm_post and the assertion header.
//
//   port     | dir | role
//   cmd      | in  | motion command: speed_magnitude, heading, rotation
//   res      | out | one transfer per wheel: wheel_index, wheel_speed, last
//   APB      | in  | wheel_count and wheel angle registers
//
// A command issues each wheel in use (1 to MAX_WHEELS) in turn through the
// single issue port into the CORDIC chain; the next command is taken while the
// last wheel issues.
// Synchronous active-high reset. A stalled res holds the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none
module omni_wheel_speed_mixer
  import owsm_pkg::*;
#(
  parameter int MAX_WHEELS         = 6,
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  owsm_cmd_if.sink         cmd,
  owsm_res_if.source       res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [2:0] wheel_count;
  logic [8:0] wheel_angle [ANGLE_REGS];
  logic [2:0] reg_idx;
  logic       reg_wr;

  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_count    <= 3'd4;
      wheel_angle[0] <= 9'd45;
      wheel_angle[1] <= 9'd135;
      wheel_angle[2] <= 9'd225;
      wheel_angle[3] <= 9'd315;
      wheel_angle[4] <= 9'd0;
      wheel_angle[5] <= 9'd0;
    end else if (reg_wr) begin
      if (reg_idx == REG_WHEEL_COUNT) begin
        wheel_count <= pwdata[2:0];
      end else if (reg_idx >= REG_ANGLE_0 && reg_idx <= REG_ANGLE_5) begin
        wheel_angle[reg_idx - REG_ANGLE_0] <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_WHEEL_COUNT) begin
      prdata = 32'(wheel_count);
    end else if (reg_idx >= REG_ANGLE_0 && reg_idx <= REG_ANGLE_5) begin
      prdata = 32'(wheel_angle[reg_idx - REG_ANGLE_0]);
    end
  end

  // ---- issue sequencer ----
  logic               adv;
  logic               busy;
  logic [2:0]         widx, n_lat, n_cfg;
  logic signed [8:0]  c_speed;
  logic [15:0]        c_heading;
  logic signed [16:0] c_rot;
  logic               last_issue, issue, accept;

  assign adv        = !res.valid || res.ready;
  assign last_issue = (widx == n_lat - 3'd1);
  assign issue      = busy && adv;
  assign cmd.ready  = adv && (!busy || last_issue);
  assign accept     = cmd.valid && cmd.ready;

  always_comb begin
    if (wheel_count == 3'd0) begin
      n_cfg = 3'd1;
    end else if (wheel_count > 3'(MAX_WHEELS)) begin
      n_cfg = 3'(MAX_WHEELS);
    end else begin
      n_cfg = wheel_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      widx <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      widx <= '0;
    end else if (issue) begin
      widx <= widx + 3'd1;
      if (last_issue) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_speed   <= cmd.speed_magnitude;
      c_heading <= cmd.heading;
      c_rot     <= cmd.rotation;
      n_lat     <= n_cfg;
    end
  end

  // degrees to turn fraction: 65536/360 = 182 rem 16, fraction part via
  // reciprocal of 45 on the small remainder term
  logic [8:0]  ang, ang_r;
  logic [9:0]  rem_y;
  logic [19:0] rem_p;
  logic [15:0] q_turn;

  always_comb begin
    ang = 9'd0;
    case (widx)
      3'd0: ang = wheel_angle[0];
      3'd1: ang = wheel_angle[1];
      3'd2: ang = wheel_angle[2];
      3'd3: ang = wheel_angle[3];
      3'd4: ang = wheel_angle[4];
      3'd5: ang = wheel_angle[5];
      default: ang = 9'd0;
    endcase
    ang_r  = (ang >= 9'd360) ? ang - 9'd360 : ang;
    rem_y  = {ang_r, 1'b0} + 10'd22;
    rem_p  = 20'(rem_y) * 20'd729;
    q_turn = 16'(ang_r) * 16'd182 + 16'(rem_p[19:15]);
  end

  function automatic cordic_vec_t prep(input logic [15:0] turn, output logic flip);
    cordic_vec_t v;
    logic signed [15:0] z;
    z    = turn;
    flip = (z > 16'sd16384) || (z < -16'sd16384);
    if (flip) begin
      z = z ^ 16'sh8000;
    end
    v.x = XW'(CORDIC_GAIN);
    v.y = '0;
    v.z = ZW'(z);
    return v;
  endfunction

  logic   s_valid [CORDIC_STEPS+1];
  stage_t s_data  [CORDIC_STEPS+1];
  stage_t s0_next;
  logic   hflip, wflip;

  always_comb begin
    s0_next.hv         = prep(c_heading, hflip);
    s0_next.wv         = prep(q_turn, wflip);
    s0_next.side.speed = c_speed;
    s0_next.side.rot   = c_rot;
    s0_next.side.idx   = widx;
    s0_next.side.last  = last_issue;
    s0_next.side.hflip = hflip;
    s0_next.side.wflip = wflip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else if (adv) begin
      s_valid[0] <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_data[0] <= s0_next;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    owsm_cordic_cell #(.STEP(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (s_valid[g]),
      .in_data   (s_data[g]),
      .out_valid (s_valid[g+1]),
      .out_data  (s_data[g+1])
    );
  end

  owsm_post #(.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_post (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_valid[CORDIC_STEPS]),
    .in_data  (s_data[CORDIC_STEPS]),
    .res      (res)
  );

  `include "omni_wheel_speed_mixer_assert.svh"

  `OWSM_ASSERT_NEXT(a_accept_starts, clk, rst, accept, busy && widx == 3'd0)
  `OWSM_ASSERT_NEXT(a_stall_holds_idx, clk, rst, busy && !adv, $stable(widx))
  `OWSM_ASSERT_NOW(a_idx_range, clk, rst, res.valid, res.wheel_index < 3'(MAX_WHEELS))

endmodule
`default_nettype wire

// ===== rtl/owsm_cordic_cell.sv =====
// One CORDIC rotation step applied to the heading and wheel-angle vectors.
// Depends on owsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module owsm_cordic_cell
  import owsm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   adv,
  input  wire logic   in_valid,
  input  wire stage_t in_data,
  output logic        out_valid,
  output stage_t      out_data
);

  localparam logic signed [ZW-1:0] ATAN = atan_turn(STEP);

  function automatic cordic_vec_t rotate(input cordic_vec_t v);
    cordic_vec_t r;
    logic signed [XW-1:0] xs, ys;
    xs = v.x >>> STEP;
    ys = v.y >>> STEP;
    if (!v.z[ZW-1]) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - ATAN;
    end else begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + ATAN;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.hv   <= rotate(in_data.hv);
      out_data.wv   <= rotate(in_data.wv);
      out_data.side <= in_data.side;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/owsm_post.sv =====
// Rounding, products, dot product with speed, rotation add and saturation.
// Depends on owsm_pkg and owsm_if.
`timescale 1ns / 1ps
`default_nettype none
module owsm_post
  import owsm_pkg::*;
#(
  parameter int TRIG_FRACTION_BITS = 14
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   adv,
  input  wire logic   in_valid,
  input  wire stage_t in_data,
  owsm_res_if.source  res
);

  localparam int S   = 16 - TRIG_FRACTION_BITS;
  localparam int TW  = TRIG_FRACTION_BITS + 3;
  localparam int PW  = 2 * TW;
  localparam int AW  = PW + 10;
  localparam int S2  = 2 * TRIG_FRACTION_BITS - 8;
  localparam logic signed [XW+1:0] RND  = (XW + 2)'((1 << S) >> 1);
  localparam logic signed [AW-1:0] RND2 = AW'(64'sd1 <<< (S2 - 1));
  localparam logic signed [AW-1:0] HI   = AW'(SPEED_MAX);
  localparam logic signed [AW-1:0] LO   = AW'(SPEED_MIN);

  function automatic logic signed [TW-1:0] rnd_trig(input logic signed [XW-1:0] v,
                                                   input logic flip);
    logic signed [XW+1:0] t;
    t = flip ? -{{2{v[XW-1]}}, v} : {{2{v[XW-1]}}, v};
    t = t + RND;
    return t[S +: TW];
  endfunction

  // rounded trig stage
  logic                 r_valid;
  logic signed [TW-1:0] sh, ch, sq, cq;
  side_t                r_side;
  // product stage
  logic                 m_valid;
  logic signed [PW-1:0] p1, p2;
  side_t                m_side;
  // speed stage
  logic                 a_valid;
  logic signed [AW-1:0] acc;
  side_t                a_side;
  // output register
  logic                 o_valid;
  logic signed [17:0]   o_speed;
  logic [2:0]           o_idx;
  logic                 o_last;

  logic signed [PW:0]   dot;
  logic signed [AW-1:0] sum;
  logic signed [17:0]   sat;

  always_comb begin
    dot = {p1[PW-1], p1} + {p2[PW-1], p2};
    sum = ((acc + RND2) >>> S2) + AW'(a_side.rot);
    if (sum > HI) begin
      sat = 18'(SPEED_MAX);
    end else if (sum < LO) begin
      sat = 18'(SPEED_MIN);
    end else begin
      sat = sum[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      m_valid <= 1'b0;
      a_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= in_valid;
      m_valid <= r_valid;
      a_valid <= m_valid;
      o_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sh      <= rnd_trig(in_data.hv.y, in_data.side.hflip);
      ch      <= rnd_trig(in_data.hv.x, in_data.side.hflip);
      sq      <= rnd_trig(in_data.wv.y, in_data.side.wflip);
      cq      <= rnd_trig(in_data.wv.x, in_data.side.wflip);
      r_side  <= in_data.side;
      p1      <= PW'(sh) * PW'(sq);
      p2      <= PW'(ch) * PW'(cq);
      m_side  <= r_side;
      acc     <= AW'(m_side.speed) * AW'(dot);
      a_side  <= m_side;
      o_speed <= sat;
      o_idx   <= a_side.idx;
      o_last  <= a_side.last;
    end
  end

  assign res.valid       = o_valid;
  assign res.wheel_speed = o_speed;
  assign res.wheel_index = o_idx;
  assign res.last        = o_last;

endmodule
`default_nettype wire
